// ----- rtl/iprt_pkg.sv -----
`timescale 1ns / 1ps
package iprt_pkg;

    typedef enum logic [1:0] {
        FN_LOOKUP  = 2'd0,
        FN_ADD     = 2'd1,
        FN_DELETE  = 2'd2,
        FN_DEFAULT = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_NOMATCH = 3'd1,
        STAT_DROP    = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_BADIDX  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_REWRITE
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    localparam int FL_UP   = 0;
    localparam int FL_GW   = 1;
    localparam int FL_HOST = 2;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [2:0]  flags;
        logic [7:0]  iface;
    } t_entry;

    // True when every byte of a is at least the matching byte of b.
    function automatic logic bytes_at_least(input logic [31:0] a, input logic [31:0] b);
        logic res;
        res = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (a[8*i +: 8] < b[8*i +: 8]) begin
                res = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/iprt_cell.sv -----
`timescale 1ns / 1ps
module iprt_cell (
    input  logic              i_clk,
    input  iprt_pkg::t_cell_op i_op,
    input  iprt_pkg::t_entry  i_new,
    input  iprt_pkg::t_entry  i_prev,
    input  iprt_pkg::t_entry  i_next,
    input  logic [31:0]       i_addr,
    input  logic [31:0]       i_mask,
    output iprt_pkg::t_entry  o_entry,
    output logic              o_match,
    output logic              o_ge,
    output logic              o_dest_zero
);
    import iprt_pkg::*;

    t_entry r_entry;

    // A rewrite keeps the destination and netmask of the entry.
    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD: begin
                r_entry <= i_new;
            end
            CELL_FROM_PREV: begin
                r_entry <= i_prev;
            end
            CELL_FROM_NEXT: begin
                r_entry <= i_next;
            end
            CELL_REWRITE: begin
                r_entry.gw    <= i_new.gw;
                r_entry.flags <= i_new.flags;
                r_entry.iface <= i_new.iface;
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

    assign o_entry     = r_entry;
    assign o_match     = ((i_addr & r_entry.mask) == r_entry.dest);
    assign o_ge        = bytes_at_least(r_entry.mask, i_mask);
    assign o_dest_zero = (r_entry.dest == 32'd0);

endmodule

// ----- rtl/iprt_sel.sv -----
`timescale 1ns / 1ps
module iprt_sel #(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0] i_req,
    input  iprt_pkg::t_entry i_entry [DEPTH],
    output logic             o_found,
    output iprt_pkg::t_entry o_entry
);
    import iprt_pkg::*;

    logic [DEPTH-1:0] w_grant;
    logic [$bits(t_entry)-1:0] w_or;

    // Lowest set request wins: x & -x isolates it.
    assign w_grant = i_req & (~i_req + DEPTH'(1));
    assign o_found = |i_req;

    always_comb begin
        w_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_or = w_or | ({$bits(t_entry){w_grant[k]}} & i_entry[k]);
        end
    end

    assign o_entry = t_entry'(w_or);

endmodule

// ----- rtl/ip_route_table_lookup_top.sv -----
`timescale 1ns / 1ps
// Ordered IPv4 route table with first-match lookup.
// Input stream: tuser carries the operation (lookup, add, delete, set default),
// tdata the destination, netmask, gateway, flags, interface and entry index.
// Output stream: one beat per input beat, tuser carries the status code and
// tdata the next hop, the outgoing interface and the entry count.
// Each table entry lives in one cell of a chain; add and delete shift the
// chain by one cell, and a lookup compares all cells at once and takes the
// lowest matching cell.
// An item is accepted in the idle state; the execute state then evaluates the
// cells and writes the result register. A new beat is accepted only after the
// previous item has left the execute state.
// The next input beat is accepted while a result still waits in the output
// register; the block then stalls in evaluation until that result is taken.
// After a synchronous reset the table is empty and no result is pending.
// Entry contents are not cleared by reset; only the entry count is.
module ip_route_table_lookup_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] dest_addr, [63:32] mask, [95:64] gw_addr, [98:96] route_flags,
    // [106:99] iface, [111:107] entry_index
    input  logic [111:0] i_s_axis_tdata,
    // [1:0] func
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] next_hop, [39:32] out_iface, [44:40] entry_count, [47:45] zero
    output logic [47:0]  o_m_axis_tdata,
    // [2:0] status
    output logic [2:0]   o_m_axis_tuser
);
    import iprt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (CW > 5) ? CW : 5;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic r_out_valid, n_out_valid;

    t_func       r_func;
    logic [31:0] r_dest, r_mask, r_gw;
    logic [2:0]  r_flags;
    logic [7:0]  r_iface;
    logic [4:0]  r_idx;

    t_status     r_out_status, n_out_status;
    logic [31:0] r_out_hop, n_out_hop;
    logic [7:0]  r_out_iface, n_out_iface;

    t_entry   w_cell_entry [TABLE_DEPTH];
    t_cell_op w_op [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_match, w_ge, w_zero, w_valid, w_hit, w_last;
    logic [TABLE_DEPTH-1:0] w_stop, w_fstop, w_above;
    t_entry w_new, w_sel_entry;
    logic   w_found, w_full, w_accept, w_advance, w_rewrite, w_bad;
    logic [IW-1:0] w_idx;

    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_advance = (r_state == S_EXEC) && (!r_out_valid || i_m_axis_tready);
    assign w_full    = (r_count == CW'(TABLE_DEPTH));

    assign w_new.dest  = (r_func == FN_DEFAULT) ? 32'd0 : r_dest;
    assign w_new.mask  = (r_func == FN_DEFAULT) ? 32'd0 : r_mask;
    assign w_new.gw    = r_gw;
    assign w_new.flags = r_flags;
    assign w_new.iface = r_iface;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            t_entry w_prev, w_next;
            if (g == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_prev
                assign w_prev = w_cell_entry[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid_next
                assign w_next = w_cell_entry[g+1];
            end

            iprt_cell u_cell (
                .i_clk       (i_clk),
                .i_op        (w_op[g]),
                .i_new       (w_new),
                .i_prev      (w_prev),
                .i_next      (w_next),
                .i_addr      (r_dest),
                .i_mask      (r_mask),
                .o_entry     (w_cell_entry[g]),
                .o_match     (w_match[g]),
                .o_ge        (w_ge[g]),
                .o_dest_zero (w_zero[g])
            );

            assign w_valid[g] = (CW'(g) < r_count);
            assign w_last[g]  = (CW'(g + 1) == r_count);
        end
    endgenerate

    assign w_hit = w_valid & w_match;

    iprt_sel #(
        .DEPTH (TABLE_DEPTH)
    ) u_sel (
        .i_req   (w_hit),
        .i_entry (w_cell_entry),
        .o_found (w_found),
        .o_entry (w_sel_entry)
    );

    // Insert point of an add: first cell that is free or whose netmask has a byte below the new netmask's.
    assign w_stop    = ~(w_valid & w_ge);
    assign w_fstop   = w_stop & (~w_stop + TABLE_DEPTH'(1));
    assign w_above   = ~(w_fstop | (w_fstop - TABLE_DEPTH'(1)));
    assign w_rewrite = |(w_last & w_zero);
    assign w_idx     = (r_idx == 5'd0) ? IW'(1) : IW'(r_idx);
    assign w_bad     = (w_idx > IW'(r_count));

    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_op[k] = CELL_HOLD;
            if (w_advance) begin
                case (r_func)
                    FN_ADD: begin
                        if (!w_full) begin
                            if (w_fstop[k]) begin
                                w_op[k] = CELL_LOAD;
                            end else if (w_above[k]) begin
                                w_op[k] = CELL_FROM_PREV;
                            end
                        end
                    end
                    FN_DELETE: begin
                        if (!w_bad && (IW'(k + 1) >= w_idx)) begin
                            w_op[k] = CELL_FROM_NEXT;
                        end
                    end
                    FN_DEFAULT: begin
                        if (w_rewrite) begin
                            if (w_last[k]) begin
                                w_op[k] = CELL_REWRITE;
                            end
                        end else if (!w_full && (CW'(k) == r_count)) begin
                            w_op[k] = CELL_LOAD;
                        end
                    end
                    default: begin
                        w_op[k] = CELL_HOLD;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_hop    = r_out_hop;
        n_out_iface  = r_out_iface;
        o_s_axis_tready = (r_state == S_IDLE);

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_advance) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_hop    = 32'd0;
                    n_out_iface  = 8'd0;
                    case (r_func)
                        FN_LOOKUP: begin
                            if (!w_found) begin
                                n_out_status = STAT_NOMATCH;
                            end else if (w_sel_entry.flags[FL_UP] &&
                                         w_sel_entry.flags[FL_HOST]) begin
                                n_out_hop   = r_dest;
                                n_out_iface = w_sel_entry.iface;
                            end else if (w_sel_entry.flags[FL_UP] &&
                                         w_sel_entry.flags[FL_GW]) begin
                                n_out_hop   = w_sel_entry.gw;
                                n_out_iface = w_sel_entry.iface;
                            end else begin
                                n_out_status = STAT_DROP;
                            end
                        end
                        FN_ADD: begin
                            if (w_full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        FN_DELETE: begin
                            if (w_bad) begin
                                n_out_status = STAT_BADIDX;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        FN_DEFAULT: begin
                            if (!w_rewrite) begin
                                if (w_full) begin
                                    n_out_status = STAT_FULL;
                                end else begin
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                        default: begin
                            n_out_status = STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= t_func'(i_s_axis_tuser);
            r_dest  <= i_s_axis_tdata[31:0];
            r_mask  <= i_s_axis_tdata[63:32];
            r_gw    <= i_s_axis_tdata[95:64];
            r_flags <= i_s_axis_tdata[98:96];
            r_iface <= i_s_axis_tdata[106:99];
            r_idx   <= i_s_axis_tdata[111:107];
        end
        r_out_status <= n_out_status;
        r_out_hop    <= n_out_hop;
        r_out_iface  <= n_out_iface;
    end

    logic [CW-1:0] r_out_count;
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_count <= n_count;
        end
    end

    logic [IW-1:0] w_out_count_ext;
    assign w_out_count_ext = IW'(r_out_count);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {3'b000, w_out_count_ext[4:0], r_out_iface, r_out_hop};

endmodule

// ----- tb/tb_ip_route_table_lookup_top.sv -----
`timescale 1ns / 1ps
module tb_ip_route_table_lookup_top;
    import iprt_pkg::*;

    localparam int DEPTH         = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int CALM_FROM     = 550;

    typedef struct packed {
        t_func       func;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [2:0]  flags;
        logic [7:0]  iface;
        logic [4:0]  idx;
    } t_route_cmd;

    typedef struct packed {
        t_status     status;
        logic [31:0] hop;
        logic [7:0]  oif;
        logic [4:0]  count;
    } t_route_resp;

    typedef struct packed {
        t_route_cmd  cmd;
        logic        typed;
        t_route_resp want;
    } t_script_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [111:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [47:0]  o_m_axis_tdata;
    logic [2:0]   o_m_axis_tuser;

    // Predicted route table and its fill level.
    t_entry      route_tbl [DEPTH];
    int          tbl_count = 0;

    t_route_resp route_replies_due[$];
    t_script_row route_script[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    logic        calm = 1'b0;
    int          stall_left = 0;

    ip_route_table_lookup_top #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // True when no byte of a is below the matching byte of b.
    function automatic bit mask_covers(logic [31:0] a, logic [31:0] b);
        for (int k = 0; k < 4; k++) begin
            if (a[8*k +: 8] < b[8*k +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_route_resp route_table_apply(t_route_cmd c);
        t_route_resp r;
        int          p;
        int          slot;
        int          del_at;
        bit          hit;
        r.status = STAT_OK;
        r.hop    = '0;
        r.oif    = '0;
        hit      = 1'b0;
        case (c.func)
            FN_LOOKUP: begin
                r.status = STAT_NOMATCH;
                for (p = 0; p < tbl_count && !hit; p++) begin
                    if ((c.dest & route_tbl[p].mask) == route_tbl[p].dest) begin
                        hit = 1'b1;
                        // Host wins over gateway when both are set.
                        if (route_tbl[p].flags[FL_UP] && route_tbl[p].flags[FL_HOST]) begin
                            r.status = STAT_OK;
                            r.hop    = c.dest;
                            r.oif    = route_tbl[p].iface;
                        end else if (route_tbl[p].flags[FL_UP] && route_tbl[p].flags[FL_GW]) begin
                            r.status = STAT_OK;
                            r.hop    = route_tbl[p].gw;
                            r.oif    = route_tbl[p].iface;
                        end else begin
                            r.status = STAT_DROP;
                        end
                    end
                end
            end
            FN_ADD: begin
                if (tbl_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    p = 0;
                    while (p < tbl_count && mask_covers(route_tbl[p].mask, c.mask)) p++;
                    for (slot = tbl_count; slot > p; slot--) route_tbl[slot] = route_tbl[slot-1];
                    route_tbl[p] = {c.dest, c.mask, c.gw, c.flags, c.iface};
                    tbl_count++;
                end
            end
            FN_DELETE: begin
                del_at = (c.idx == 0) ? 1 : int'(c.idx);
                if (del_at > tbl_count) begin
                    r.status = STAT_BADIDX;
                end else begin
                    for (slot = del_at - 1; slot + 1 < tbl_count; slot++) begin
                        route_tbl[slot] = route_tbl[slot+1];
                    end
                    tbl_count--;
                end
            end
            default: begin
                if (tbl_count > 0 && route_tbl[tbl_count-1].dest == '0) begin
                    // A trailing default route is rewritten in place, mask kept.
                    route_tbl[tbl_count-1].gw    = c.gw;
                    route_tbl[tbl_count-1].flags = c.flags;
                    route_tbl[tbl_count-1].iface = c.iface;
                end else if (tbl_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    route_tbl[tbl_count] = {32'h0, 32'h0, c.gw, c.flags, c.iface};
                    tbl_count++;
                end
            end
        endcase
        r.count = tbl_count[4:0];
        return r;
    endfunction

    function automatic t_route_cmd random_route_cmd(int add_pct, int del_pct);
        t_route_cmd  c;
        int unsigned roll;
        int unsigned plen;
        int          k;
        c.func  = FN_LOOKUP;
        c.dest  = $urandom;
        c.mask  = $urandom;
        c.gw    = $urandom;
        c.flags = 3'($urandom_range(0, 7));
        c.iface = 8'($urandom_range(0, 255));
        c.idx   = 5'($urandom_range(0, DEPTH));
        roll    = $urandom_range(0, 99);
        if (roll < add_pct) begin
            c.func = FN_ADD;
            if ($urandom_range(0, 4) != 0) begin
                plen   = $urandom_range(0, 32);
                c.mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
            end
            // Mostly a destination that lies inside its own mask, so it can match.
            if ($urandom_range(0, 7) != 0) c.dest = c.dest & c.mask;
        end else if (roll < add_pct + del_pct) begin
            c.func = FN_DELETE;
            if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
                c.idx = 5'($urandom_range(1, tbl_count));
            end
        end else if (roll < add_pct + del_pct + 8) begin
            c.func = FN_DEFAULT;
        end else if (tbl_count > 0 && $urandom_range(0, 7) != 0) begin
            k      = $urandom_range(0, tbl_count - 1);
            c.dest = route_tbl[k].dest | ($urandom & ~route_tbl[k].mask);
        end
        return c;
    endfunction

    task automatic script_row(input t_func f, input logic [31:0] dest, input logic [31:0] mask,
                              input logic [31:0] gw, input logic [2:0] fl,
                              input logic [7:0] ifc, input logic [4:0] idx, input logic typed,
                              input t_status st, input logic [31:0] hop,
                              input logic [7:0] oif, input logic [4:0] cnt);
        t_script_row row;
        row.cmd   = '{func: f, dest: dest, mask: mask, gw: gw, flags: fl, iface: ifc, idx: idx};
        row.typed = typed;
        row.want  = '{status: st, hop: hop, oif: oif, count: cnt};
        route_script.insert(route_script.size(), row);
    endtask

    task automatic send_route_cmd(input t_route_cmd c, input logic typed,
                                  input t_route_resp want);
        t_route_resp pred;
        int          gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.func;
        s_tdata  <= {c.idx, c.iface, c.flags, c.gw, c.mask, c.dest};
        do @(negedge i_clk); while (!o_s_axis_tready);
        @(posedge i_clk);
        pred = route_table_apply(c);
        route_replies_due.insert(route_replies_due.size(), typed ? want : pred);
    endtask

    // Receiver side: random stall bursts until the calm tail of the run.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && i_rst_n && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // Handshakes are judged at the falling edge, where every signal is settled;
    // a beat seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_route_resp exp;
        if (i_rst_n) begin
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("tb_ip_route_table_lookup_top: FAIL");
                $finish;
            end
            if (o_m_axis_tvalid && m_tready) begin
                if (route_replies_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, actual tuser %0d tdata %h",
                             $time, o_m_axis_tuser, o_m_axis_tdata);
                end else begin
                    exp = route_replies_due.pop_front();
                    if (o_m_axis_tuser != exp.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp.status, o_m_axis_tuser);
                    end
                    if (o_m_axis_tdata[31:0] != exp.hop) begin
                        mismatches++;
                        $display("%0t: next_hop expected %h actual %h",
                                 $time, exp.hop, o_m_axis_tdata[31:0]);
                    end
                    if (o_m_axis_tdata[39:32] != exp.oif) begin
                        mismatches++;
                        $display("%0t: out_iface expected %0d actual %0d",
                                 $time, exp.oif, o_m_axis_tdata[39:32]);
                    end
                    if (o_m_axis_tdata[44:40] != exp.count) begin
                        mismatches++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, exp.count, o_m_axis_tdata[44:40]);
                    end
                end
            end
        end
    end

    initial begin
        t_route_resp none;
        int          add_pct;
        int          del_pct;
        none = '{status: STAT_OK, hop: 32'h0, oif: 8'h0, count: 5'd0};

        // Empty table: lookup misses and delete has nothing to remove.
        script_row(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b1,
                   STAT_NOMATCH, 32'h0, 8'd0, 5'd0);
        script_row(FN_DELETE, 32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b1,
                   STAT_BADIDX, 32'h0, 8'd0, 5'd0);
        script_row(FN_DELETE, 32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 5'd16, 1'b1,
                   STAT_BADIDX, 32'h0, 8'd0, 5'd0);
        // Default route appended to the empty table, then rewritten with several flag mixes.
        script_row(FN_DEFAULT, 32'h0, 32'h0, 32'hFFFF_FFFF, 3'd7, 8'd255, 5'd0, 1'b1,
                   STAT_OK, 32'h0, 8'd0, 5'd1);
        script_row(FN_LOOKUP, 32'hC0A8_0101, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b1,
                   STAT_OK, 32'hC0A8_0101, 8'd255, 5'd1);
        script_row(FN_DEFAULT, 32'h0, 32'h0, 32'h0A00_0001, 3'd3, 8'd7, 5'd0, 1'b1,
                   STAT_OK, 32'h0, 8'd0, 5'd1);
        script_row(FN_LOOKUP, 32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b1,
                   STAT_OK, 32'h0A00_0001, 8'd7, 5'd1);
        script_row(FN_DEFAULT, 32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b1,
                   STAT_OK, 32'h0, 8'd0, 5'd1);
        script_row(FN_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b1,
                   STAT_DROP, 32'h0, 8'd0, 5'd1);
        script_row(FN_DEFAULT, 32'h0, 32'h0, 32'h5555_5555, 3'd1, 8'd9, 5'd0, 1'b1,
                   STAT_OK, 32'h0, 8'd0, 5'd1);
        script_row(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b1,
                   STAT_DROP, 32'h0, 8'd0, 5'd1);
        script_row(FN_DEFAULT, 32'h0, 32'h0, 32'hAAAA_AAAA, 3'd6, 8'd1, 5'd0, 1'b1,
                   STAT_OK, 32'h0, 8'd0, 5'd1);
        script_row(FN_LOOKUP, 32'h0000_0001, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b1,
                   STAT_DROP, 32'h0, 8'd0, 5'd1);
        // Specific routes go ahead of the default; ordering follows the masks.
        script_row(FN_ADD, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0, 3'd5, 8'd1, 5'd0, 1'b1,
                   STAT_OK, 32'h0, 8'd0, 5'd2);
        script_row(FN_ADD, 32'hC0A8_0105, 32'hFFFF_FFFF, 32'h0102_0304, 3'd3, 8'd2, 5'd0,
                   1'b0, STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_ADD, 32'h0A00_0000, 32'hFF00_FF00, 32'h0A00_00FE, 3'd3, 8'd3, 5'd0,
                   1'b0, STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_LOOKUP, 32'hC0A8_0105, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b0,
                   STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_LOOKUP, 32'hC0A8_0277, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b0,
                   STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_LOOKUP, 32'h0A55_0001, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b0,
                   STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_LOOKUP, 32'h0808_0808, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b0,
                   STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_DELETE, 32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 5'd2, 1'b0,
                   STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_DELETE, 32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 5'd5, 1'b0,
                   STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_DELETE, 32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b0,
                   STAT_OK, 32'h0, 8'd0, 5'd0);
        script_row(FN_LOOKUP, 32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 5'd0, 1'b0,
                   STAT_OK, 32'h0, 8'd0, 5'd0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (route_script[n]) begin
            send_route_cmd(route_script[n].cmd, route_script[n].typed, route_script[n].want);
        end

        add_pct = 25;
        del_pct = 20;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Alternate filling, draining and mixed stretches so the table
            // regularly runs full and empty.
            if (n % 50 == 0) begin
                case ((n / 50) % 3)
                    0: begin add_pct = 55; del_pct = 10; end
                    1: begin add_pct = 10; del_pct = 50; end
                    default: begin add_pct = 25; del_pct = 20; end
                endcase
            end
            if (n == CALM_FROM) calm <= 1'b1;
            send_route_cmd(random_route_cmd(add_pct, del_pct), 1'b0, none);
            if (n % 150 == 75) begin
                s_tvalid <= 1'b0;
                while (route_replies_due.size() != 0) @(posedge i_clk);
            end
        end

        s_tvalid <= 1'b0;
        while (route_replies_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_ip_route_table_lookup_top: PASS");
        end else begin
            $display("tb_ip_route_table_lookup_top: FAIL");
        end
        $finish;
    end

endmodule
